/* hdl/srcc_pkg.sv */
// Shared types, constants and the CRC-8 step for the sensor reply checker.
// Used by srcc_conv and sensor_reply_check_convert; depends on nothing else.
`default_nettype none

package srcc_pkg;

    // Byte position inside one three-byte sensor reply.
    typedef enum logic [1:0] {
        POS_HIGH  = 2'd0,
        POS_LOW   = 2'd1,
        POS_CHECK = 2'd2
    } t_pos;

    // One finished reply handed to the conversion pipeline.
    typedef struct packed {
        logic [13:0] raw;     // raw word with the two status bits dropped
        logic        humid;   // 1: humidity, 0: temperature
        logic        bad;     // checksum mismatch
    } t_conv_item;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] TEMP_GAIN   = 15'd17572;
    localparam logic [14:0] HUM_GAIN    = 15'd12500;
    // Offsets already scaled by 100 * 65536.
    localparam logic [30:0] TEMP_OFFSET = 31'd307036160;
    localparam logic [30:0] HUM_OFFSET  = 31'd39321600;
    // floor(q / 100) == (q * RECIP_100) >> RECIP_SHIFT for every q below 16384.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // One CRC-8 byte update, MSB first, no final xor.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/srcc_conv.sv */
// Conversion pipeline: raw sensor word to signed whole degrees or percent.
// Three register stages with per-stage valid; depends on srcc_pkg.
`default_nettype none

module srcc_conv (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire srcc_pkg::t_conv_item i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [8:0]        o_reading,
    output logic                     o_checksum_bad
);
    import srcc_pkg::*;

    // Stage A: gain times raw word.
    logic        r_va;
    logic [30:0] r_prod;
    logic        r_humid_a;
    logic        r_bad_a;
    // Stage B: magnitude divided by 65536, with its sign.
    logic        r_vb;
    logic [13:0] r_quot;
    logic        r_neg_b;
    logic        r_bad_b;
    // Output register.
    logic        r_vo;
    logic signed [8:0] r_reading;
    logic        r_bad_o;

    logic        adv_o;
    logic        adv_b;
    logic        adv_a;

    logic [14:0] gain;
    logic [30:0] n_prod;
    logic signed [31:0] diff;
    logic [31:0] mag;
    logic [26:0] scaled;
    logic [7:0]  whole;
    logic signed [8:0] n_reading;

    assign adv_o   = !r_vo || i_ready;
    assign adv_b   = !r_vb || adv_o;
    assign adv_a   = !r_va || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        gain   = i_item.humid ? HUM_GAIN : TEMP_GAIN;
        n_prod = 31'(gain) * 31'({i_item.raw, 2'b00});
    end

    always_comb begin
        diff = $signed({1'b0, r_prod}) -
               $signed({1'b0, (r_humid_a ? HUM_OFFSET : TEMP_OFFSET)});
        mag  = diff[31] ? 32'(-diff) : 32'(diff);
    end

    always_comb begin
        scaled = 27'(r_quot) * 27'(RECIP_100);
        whole  = scaled[RECIP_SHIFT +: 8];
        if (r_bad_b) begin
            n_reading = '0;
        end else if (r_neg_b) begin
            n_reading = -$signed({1'b0, whole});
        end else begin
            n_reading = $signed({1'b0, whole});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv_a) begin
                r_va <= i_valid;
            end
            if (adv_b) begin
                r_vb <= r_va;
            end
            if (adv_o) begin
                r_vo <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_prod    <= n_prod;
            r_humid_a <= i_item.humid;
            r_bad_a   <= i_item.bad;
        end
        if (adv_b && r_va) begin
            r_quot  <= mag[29:16];
            r_neg_b <= diff[31];
            r_bad_b <= r_bad_a;
        end
        if (adv_o && r_vb) begin
            r_reading <= n_reading;
            r_bad_o   <= r_bad_b;
        end
    end

    assign o_valid        = r_vo;
    assign o_reading      = r_reading;
    assign o_checksum_bad = r_bad_o;

endmodule

`default_nettype wire

/* hdl/sensor_reply_check_convert.sv */
// Top level: sensor reply byte collector with CRC-8 check and unit conversion.
// Depends on srcc_pkg and srcc_conv.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_reply_byte, i_measure_humidity
// output    out        o_out_valid / i_out_ready o_reading, o_checksum_bad
//
// One byte beat is accepted per cycle while the pipeline has room.
// Only the checksum beat of a reply yields a result: the beat loads the reply
// register, then the gain multiply into stage A, the offset subtract and scale
// into stage B, and the reciprocal multiply into the output register follow in
// order. Each stage holds its own valid bit, so a stalled output does not stop
// intake until every stage is full.
// Reset is synchronous and active low; it clears the byte position, the CRC and
// all valid bits.

module sensor_reply_check_convert (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [7:0]        i_reply_byte,
    input  wire               i_measure_humidity,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [8:0] o_reading,
    output logic              o_checksum_bad
);
    import srcc_pkg::*;

    // Reply collection state.
    t_pos       r_pos;
    t_pos       n_pos;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] r_high;
    logic [7:0] r_low;

    // Finished reply waiting for the conversion pipeline.
    logic       r_item_valid;
    t_conv_item r_item;
    t_conv_item n_item;

    logic       conv_ready;
    logic       in_beat;
    logic [7:0] crc_upd;

    assign o_in_ready = !r_item_valid || conv_ready;
    assign in_beat    = i_in_valid && o_in_ready;
    assign crc_upd    = crc8_step(r_crc, i_reply_byte);

    // Next byte position. A beat moves high -> low -> checksum -> high.
    always_comb begin
        n_pos = r_pos;
        if (in_beat) begin
            unique case (r_pos)
                POS_HIGH:  n_pos = POS_LOW;
                POS_LOW:   n_pos = POS_CHECK;
                POS_CHECK: n_pos = POS_HIGH;
                default:   n_pos = POS_HIGH;
            endcase
        end
    end

    // Per-position outputs: CRC update and the item for the pipeline.
    always_comb begin
        n_crc      = r_crc;
        n_item.raw   = {r_high, r_low[7:2]};
        n_item.humid = i_measure_humidity;
        n_item.bad   = (i_reply_byte != r_crc);
        unique case (r_pos)
            POS_HIGH:  n_crc = crc_upd;
            POS_LOW:   n_crc = crc_upd;
            POS_CHECK: n_crc = '0;
            default:   n_crc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_HIGH;
            r_crc        <= '0;
            r_high       <= '0;
            r_low        <= '0;
            r_item_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_pos <= n_pos;
                r_crc <= n_crc;
                if (r_pos == POS_HIGH) begin
                    r_high <= i_reply_byte;
                end
                if (r_pos == POS_LOW) begin
                    r_low <= i_reply_byte;
                end
            end
            // The checksum beat loads a new item; otherwise the pipeline drains it.
            if (in_beat && r_pos == POS_CHECK) begin
                r_item_valid <= 1'b1;
            end else if (conv_ready) begin
                r_item_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && r_pos == POS_CHECK) begin
            r_item <= n_item;
        end
    end

    srcc_conv u_conv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_item_valid),
        .o_ready        (conv_ready),
        .i_item         (r_item),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_reading      (o_reading),
        .o_checksum_bad (o_checksum_bad)
    );

    // A failed checksum always comes out with a zero reading.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_checksum_bad |-> o_reading == 9'sd0)
        else $error("checksum failure with nonzero reading");

    // The checksum beat restarts the CRC and hands an item to the pipeline.
    a_check_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && r_pos == POS_CHECK |=> r_crc == 8'h00 && r_item_valid && r_pos == POS_HIGH)
        else $error("checksum beat did not close the reply");

    // Data beats never create a pipeline item.
    a_data_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && r_pos != POS_CHECK && !r_item_valid |=> !r_item_valid)
        else $error("item created by a data beat");

endmodule

`default_nettype wire
